>>> src/gbr_pkg.sv
// ----------------------------------------------------------------------------
// Glyph bitmap rasterizer package
// Shared constants, codes and types of the glyph bitmap rasterizer.
// ----------------------------------------------------------------------------
package gbr_pkg;

    // Number of lanes, one per bit of a bitmap byte.
    localparam int LANES = 8;

    // Limits applied to the configuration registers.
    localparam logic [4:0] SCALE_MAX = 5'd16;
    localparam logic [6:0] ROWS_MAX  = 7'd64;

    // Input operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SCALE = 2'd0,
        CFG_ROWS  = 2'd1,
        CFG_COLOR = 2'd2
    } t_cfg_idx;

    // X coordinates of all lanes for one byte.
    typedef logic [LANES-1:0][15:0] t_px_vec;

    // What the lane stage hands to the merge stage besides the x coordinates.
    typedef struct packed {
        logic [LANES-1:0] mask;
        logic [15:0]      py;
        logic [15:0]      color;
    } t_stage;

endpackage

>>> src/gbr_lane.sv
// ----------------------------------------------------------------------------
// Glyph bitmap rasterizer lane
// Computes and registers the scaled x coordinate of one bit of a bitmap byte.
// ----------------------------------------------------------------------------
module gbr_lane (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [2:0]  i_lane,
    input  logic [4:0]  i_byte_index,
    input  logic [7:0]  i_width,
    input  logic        i_mirror,
    input  logic [15:0] i_origin_x,
    input  logic [4:0]  i_scale,
    output logic [15:0] o_px
);
    import gbr_pkg::*;

    logic [7:0]  w_col;
    logic [15:0] w_pos;
    logic [20:0] w_prod;
    logic [15:0] r_px;
    logic [15:0] n_px;

    // Bit k of a byte is column byte*8 + 7 - k, since the MSB is leftmost.
    assign w_col  = {i_byte_index, 3'd7 - i_lane};
    assign w_pos  = i_mirror ? ({8'd0, i_width} - 16'd1 - {8'd0, w_col})
                             : {8'd0, w_col};
    assign w_prod = {5'd0, w_pos} * {16'd0, i_scale};
    assign n_px   = i_origin_x + w_prod[15:0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_px <= n_px;
        end
    end

    assign o_px = r_px;

endmodule

>>> src/gbr_merge.sv
// ----------------------------------------------------------------------------
// Glyph bitmap rasterizer merge stage
// Serializes the set bits of one byte, lowest bit first, into output words.
// ----------------------------------------------------------------------------
module gbr_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  gbr_pkg::t_stage      i_stage,
    input  gbr_pkg::t_px_vec     i_px,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [15:0]   o_pixel_x,
    output logic signed [15:0]   o_pixel_y,
    output logic [15:0]          o_color,
    output logic                 o_last_pixel
);
    import gbr_pkg::*;

    logic [LANES-1:0] r_mask;
    logic [LANES-1:0] n_mask;
    t_px_vec          r_px;
    logic [15:0]      r_py;
    logic [15:0]      r_color;
    logic             r_ov;
    logic             n_ov;
    logic [15:0]      r_ox;
    logic [15:0]      r_oy;
    logic [15:0]      r_oc;
    logic             r_olast;
    logic [LANES-1:0] w_low;
    logic [LANES-1:0] w_rest;
    logic             w_issue;
    logic [15:0]      w_sel_x;

    assign w_low   = r_mask & (~r_mask + 1'b1);
    assign w_rest  = r_mask & ~w_low;
    assign w_issue = (r_mask != '0) && (!r_ov || i_ready);
    assign o_free  = (r_mask == '0) || (w_issue && (w_rest == '0));

    always_comb begin
        w_sel_x = '0;
        for (int k = 0; k < LANES; k++) begin
            w_sel_x = w_sel_x | (w_low[k] ? r_px[k] : 16'd0);
        end
    end

    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            n_mask = i_stage.mask;
        end else if (w_issue) begin
            n_mask = w_rest;
        end
        n_ov = r_ov;
        if (w_issue) begin
            n_ov = 1'b1;
        end else if (i_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_mask <= n_mask;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_px    <= i_px;
            r_py    <= i_stage.py;
            r_color <= i_stage.color;
        end
        if (w_issue) begin
            r_ox    <= w_sel_x;
            r_oy    <= r_py;
            r_oc    <= r_color;
            r_olast <= (w_rest == '0);
        end
    end

    assign o_valid      = r_ov;
    assign o_pixel_x    = r_ox;
    assign o_pixel_y    = r_oy;
    assign o_color      = r_oc;
    assign o_last_pixel = r_olast;

endmodule

>>> src/glyph_bitmap_rasterizer.sv
// ----------------------------------------------------------------------------
// Glyph bitmap rasterizer
// Turns packed 1-bit glyph bitmaps into scaled pixel fill commands.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_valid / o_ready) takes one word per handshake.
// A start word (op 0) latches the glyph origin, width and mirror flag and
// clears the row and byte counters; it produces nothing. A byte word (op 1)
// carries one bitmap byte, row-major, (width+7)/8 bytes per row, and yields
// one output word (o_valid / i_ready) per set bit, lowest bit first, with
// o_last_pixel marking the final word of that byte.
// A byte passes through the lane stage registers, the merge stage and the
// output register. The merge stage sends one word per cycle while the
// receiver is ready, and the lane stage can take the next byte while the
// merge stage still serializes the last one. Eight lanes compute all x
// coordinates of a byte in parallel and register them when it is taken.
// When the receiver stalls, the output register holds its word and the lane
// and merge stages fill up before o_ready drops.
// Reset (synchronous, active low) empties the pipeline, restores the state
// to origin (0,0), width 8, no mirroring, and the registers to scale 1,
// eight rows and color 0xFFFF. Configuration should be written only while
// the block is idle; a byte in flight keeps the settings it was taken with.
// ----------------------------------------------------------------------------
module glyph_bitmap_rasterizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic [7:0]         i_glyph_width,
    input  logic               i_mirror,
    input  logic [7:0]         i_glyph_bits,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_pixel_x,
    output logic signed [15:0] o_pixel_y,
    output logic [15:0]        o_color,
    output logic               o_last_pixel
);
    import gbr_pkg::*;

    // Configuration registers.
    logic [4:0]  r_scale;
    logic [6:0]  r_rows;
    logic [15:0] r_color;

    // Glyph state.
    logic [15:0] r_origin_x;
    logic [15:0] r_origin_y;
    logic [7:0]  r_width;
    logic        r_mirror;
    logic [5:0]  r_row;
    logic [4:0]  r_byte;
    logic [5:0]  n_row;
    logic [4:0]  n_byte;

    // Lane stage bookkeeping.
    logic        r_sa_valid;
    logic        n_sa_valid;
    t_stage      r_sa;
    t_px_vec     w_px;

    logic        w_accept;
    logic        w_accept_byte;
    logic        w_merge_free;
    logic        w_sa_move;
    logic [4:0]  w_scale;
    logic [6:0]  w_eff_rows;
    logic [8:0]  w_width_sum;
    logic [5:0]  w_bpr_raw;
    logic [5:0]  w_bpr;
    logic [5:0]  w_byte_inc;
    logic [6:0]  w_row_inc;
    logic [10:0] w_row_off;

    // Out-of-range register values are clamped into their legal ranges.
    assign w_scale    = (r_scale == 5'd0) ? 5'd1
                      : ((r_scale > SCALE_MAX) ? SCALE_MAX : r_scale);
    assign w_eff_rows = (r_rows == 7'd0) ? 7'd1
                      : ((r_rows > ROWS_MAX) ? ROWS_MAX : r_rows);

    // Bytes per row; a zero width still counts as one byte.
    assign w_width_sum = {1'b0, r_width} + 9'd7;
    assign w_bpr_raw   = w_width_sum[8:3];
    assign w_bpr       = (w_bpr_raw == 6'd0) ? 6'd1 : w_bpr_raw;

    assign w_sa_move     = r_sa_valid && w_merge_free;
    assign o_ready       = !r_sa_valid || w_sa_move;
    assign w_accept      = i_valid && o_ready;
    assign w_accept_byte = w_accept && (i_op == OP_BYTE);

    // Advance the byte and row counters after each byte.
    assign w_byte_inc = {1'b0, r_byte} + 6'd1;
    assign w_row_inc  = {1'b0, r_row} + 7'd1;

    always_comb begin
        n_byte = w_byte_inc[4:0];
        n_row  = r_row;
        if (w_byte_inc >= w_bpr) begin
            n_byte = 5'd0;
            n_row  = (w_row_inc >= w_eff_rows) ? 6'd0 : w_row_inc[5:0];
        end
    end

    always_comb begin
        n_sa_valid = r_sa_valid;
        if (w_accept_byte) begin
            n_sa_valid = 1'b1;
        end else if (w_sa_move) begin
            n_sa_valid = 1'b0;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 5'd1;
            r_rows  <= 7'd8;
            r_color <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE: r_scale <= i_cfg_data[4:0];
                CFG_ROWS:  r_rows  <= i_cfg_data[6:0];
                CFG_COLOR: r_color <= i_cfg_data;
                default:   r_scale <= r_scale;
            endcase
        end
    end

    // Glyph state: a start word reloads it, a byte word steps the counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= 16'd0;
            r_origin_y <= 16'd0;
            r_width    <= 8'd8;
            r_mirror   <= 1'b0;
            r_row      <= 6'd0;
            r_byte     <= 5'd0;
            r_sa_valid <= 1'b0;
        end else begin
            r_sa_valid <= n_sa_valid;
            if (w_accept) begin
                if (i_op == OP_START) begin
                    r_origin_x <= i_start_x;
                    r_origin_y <= i_start_y;
                    r_width    <= i_glyph_width;
                    r_mirror   <= i_mirror;
                    r_row      <= 6'd0;
                    r_byte     <= 5'd0;
                end else begin
                    r_row  <= n_row;
                    r_byte <= n_byte;
                end
            end
        end
    end

    // Row offset is shared by every pixel of the byte.
    assign w_row_off = {5'd0, r_row} * {6'd0, w_scale};

    always_ff @(posedge i_clk) begin
        if (w_accept_byte) begin
            r_sa.mask  <= i_glyph_bits;
            r_sa.py    <= r_origin_y + {5'd0, w_row_off};
            r_sa.color <= r_color;
        end
    end

    // One lane per bit of the byte; lane k serves bit k.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        gbr_lane u_lane (
            .i_clk        (i_clk),
            .i_load       (w_accept_byte),
            .i_lane       (3'(g)),
            .i_byte_index (r_byte),
            .i_width      (r_width),
            .i_mirror     (r_mirror),
            .i_origin_x   (r_origin_x),
            .i_scale      (w_scale),
            .o_px         (w_px[g])
        );
    end

    gbr_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_sa_move),
        .i_stage      (r_sa),
        .i_px         (w_px),
        .o_free       (w_merge_free),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_color      (o_color),
        .o_last_pixel (o_last_pixel)
    );

`ifndef SYNTHESIS
    // A start word clears both counters.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_START)) |=> ((r_row == 6'd0) && (r_byte == 5'd0)))
        else $error("start word did not clear the counters");

    // The byte counter stays inside the row after each byte.
    a_byte_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept_byte |=> ({1'b0, r_byte} < w_bpr))
        else $error("byte counter ran past the end of the row");

    // An empty lane stage never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sa_valid |-> o_ready)
        else $error("input stalled with an empty lane stage");
`endif

endmodule
